>>> rtl/core/cmfr_pkg.sv
// Shared types and constants for the CAN mailbox filter rotator.
`timescale 1ns / 1ps
package cmfr_pkg;
	localparam int MAILBOXES    = 16;
	localparam int MAX_MESSAGES = 64;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_RX     = 2'd1;
	localparam logic [1:0] OP_ASSIGN = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  mbox;
		logic [5:0]  entry_index;
		logic [10:0] entry_id;
		logic [14:0] entry_reload;
		logic [3:0]  entry_dlc;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  out_mailbox;
		logic        assigned;
		logic [10:0] assigned_id;
		logic [3:0]  assigned_dlc;
		logic [5:0]  assigned_entry;
		logic [5:0]  rx_entry;
		logic [31:0] entry0_count;
		logic [31:0] total_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_SCAN, ST_DONE
	} state_t;
endpackage

>>> rtl/core/cmfr_fifo.sv
// Small word queue between front and back.
`timescale 1ns / 1ps
module cmfr_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic do_wr, do_rd;
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end
endmodule

>>> rtl/core/cmfr_engine.sv
// Back end: table storage, round-robin mailbox assignment scan.
`timescale 1ns / 1ps
module cmfr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [6:0]        num_messages,
	input  logic              cmd_valid,
	input  cmfr_pkg::cmd_t    cmd,
	output logic              cmd_take,
	output logic              res_valid,
	output cmfr_pkg::res_t    res,
	input  logic              res_full
);
	import cmfr_pkg::*;
	localparam int AW = $clog2(MAX_MESSAGES);
	localparam int MW = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
	localparam int NW = AW + 1;

	logic [10:0] id_mem [MAX_MESSAGES];
	logic [14:0] rl_mem [MAX_MESSAGES];
	logic [3:0]  dlc_mem [MAX_MESSAGES];
	logic [15:0] tm_mem [MAX_MESSAGES];
	logic [10:0] fid_q [MAILBOXES];
	logic [5:0]  fent_q [MAILBOXES];

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [AW-1:0] last_q, idx_q;
	logic last_vld_q;
	logic [NW-1:0] k_q, n_q;
	logic [31:0] total_q, e0_q;
	logic got_q;
	logic [5:0] rx_q, ch_q;
	logic [10:0] rid_q, aid_q;
	logic [14:0] rrl_q;
	logic [3:0] rdlc_q, adlc_q;
	logic [15:0] rtm_q;

	logic mb_ok, present, hit;
	logic [15:0] tm_dec;
	logic [NW-1:0] n_eff;
	logic [AW-1:0] start, nxt, rd_addr;
	logic [AW-1:0] rx_idx;
	logic [MW-1:0] mb;

	assign mb = cmd_q.mbox[MW-1:0];
	assign mb_ok = {1'b0, cmd_q.mbox} < 5'(MAILBOXES);
	assign n_eff = (num_messages == 7'd0) ? NW'(1) :
		(32'(num_messages) > 32'(MAX_MESSAGES)) ? NW'(MAX_MESSAGES) : NW'(num_messages);
	assign start = (last_vld_q && {1'b0, last_q} < n_eff) ?
		(({1'b0, last_q} + NW'(1) >= n_eff) ? '0 : last_q + AW'(1)) : '0;
	assign nxt = ({1'b0, idx_q} + NW'(1) >= n_q) ? '0 : idx_q + AW'(1);
	assign rx_idx = fent_q[mb][AW-1:0];
	// table read runs one entry ahead during the scan
	assign rd_addr = (state_q == ST_SCAN) ? nxt : idx_q;
	assign hit = $signed(tm_dec) <= 0;

	always_comb begin
		present = 1'b0;
		for (int m = 0; m < MAILBOXES; m++)
			if (fid_q[m] == rid_q) present = 1'b1;
		tm_dec = rtm_q;
		if (!present && rtm_q != 16'h8000) tm_dec = rtm_q - 16'd1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (cmd_valid) state_d = ST_RD;
			ST_RD: begin
				if (!(cmd_q.op inside {OP_RX, OP_ASSIGN}) || !mb_ok)
					state_d = ST_DONE;
				else state_d = ST_SCAN;
			end
			ST_SCAN: if (hit || k_q + NW'(1) >= n_q) state_d = ST_DONE;
			ST_DONE: if (!res_full) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign cmd_take = state_q == ST_IDLE && cmd_valid;
	assign res_valid = state_q == ST_DONE;

	always_comb begin
		res = '0;
		res.out_mailbox = cmd_q.mbox;
		res.assigned = got_q;
		if (got_q) begin
			res.assigned_id = aid_q;
			res.assigned_dlc = adlc_q;
			res.assigned_entry = ch_q;
		end
		res.rx_entry = rx_q;
		res.entry0_count = e0_q;
		res.total_count = total_q;
	end

	always_ff @(posedge clk) begin
		rid_q <= id_mem[rd_addr];
		rrl_q <= rl_mem[rd_addr];
		rdlc_q <= dlc_mem[rd_addr];
		rtm_q <= tm_mem[rd_addr];
		if (cmd_take) cmd_q <= cmd;
		if (cmd_take && cmd.op == OP_LOAD &&
			32'(cmd.entry_index) < 32'(MAX_MESSAGES)) begin
			id_mem[cmd.entry_index[AW-1:0]] <= cmd.entry_id;
			rl_mem[cmd.entry_index[AW-1:0]] <= cmd.entry_reload;
			dlc_mem[cmd.entry_index[AW-1:0]] <= cmd.entry_dlc;
			tm_mem[cmd.entry_index[AW-1:0]] <= {1'b0, cmd.entry_reload};
		end
		if (state_q == ST_SCAN)
			tm_mem[idx_q] <= hit ? {1'b0, rrl_q} : tm_dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q <= '0; last_vld_q <= 1'b0;
			idx_q <= '0; k_q <= '0; n_q <= '0;
			total_q <= '0; e0_q <= '0; got_q <= 1'b0; rx_q <= '0; ch_q <= '0;
			aid_q <= '0; adlc_q <= '0;
			for (int m = 0; m < MAILBOXES; m++) begin
				fid_q[m] <= '0; fent_q[m] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (cmd_valid) begin
					got_q <= 1'b0; rx_q <= '0; ch_q <= '0;
					idx_q <= start; k_q <= '0; n_q <= n_eff;
				end
				ST_RD: if (cmd_q.op == OP_RX && mb_ok) begin
					total_q <= total_q + 32'd1;
					rx_q <= fent_q[mb];
					if (rx_idx == '0) e0_q <= e0_q + 32'd1;
				end
				ST_SCAN: begin
					if (hit) begin
						got_q <= 1'b1; ch_q <= 6'(idx_q);
						aid_q <= rid_q; adlc_q <= rdlc_q;
						last_q <= idx_q; last_vld_q <= 1'b1;
						fid_q[mb] <= rid_q;
						fent_q[mb] <= 6'(idx_q);
					end
					idx_q <= nxt; k_q <= k_q + NW'(1);
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/core/can_mailbox_filter_rotator.sv
// Top level: input queue, assignment engine, result queue.
//  channel | handshake      | words
//  in      | push / full    | op, mbox, entry_*
//  out     | pop / empty    | out_mailbox .. total_count
//  cfg     | cfg_we         | num_messages
// An item's time grows with the table entries scanned; the engine takes no new item until the last is done.
// The scan loop over the table, one entry per cycle, sets the rate.
// Reset clears counts, mailboxes and queues; table contents stay undefined until loaded.
// Either side may stall alone; two-word queues sit on each side of the engine.
`timescale 1ns / 1ps
module can_mailbox_filter_rotator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [3:0]  mbox,
	input  logic [5:0]  entry_index,
	input  logic [10:0] entry_id,
	input  logic [14:0] entry_reload,
	input  logic [3:0]  entry_dlc,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  out_mailbox,
	output logic        assigned,
	output logic [10:0] assigned_id,
	output logic [3:0]  assigned_dlc,
	output logic [5:0]  assigned_entry,
	output logic [5:0]  rx_entry,
	output logic [31:0] entry0_count,
	output logic [31:0] total_count
);
	import cmfr_pkg::*;
	logic [6:0] num_q;
	cmd_t cin, cout;
	res_t rin, rout;
	logic cq_empty, take, rv, rq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_q <= 7'd1;
		else if (cfg_we) num_q <= cfg_wdata;
	end

	assign cin = '{op, mbox, entry_index, entry_id, entry_reload, entry_dlc};

	cmfr_fifo #(.W($bits(cmd_t))) u_cq (
		.clk, .arst_n, .wr(push), .wdata(cin), .full,
		.rd(take), .rdata(cout), .empty(cq_empty)
	);

	cmfr_engine u_eng (
		.clk, .arst_n, .num_messages(num_q), .cmd_valid(!cq_empty), .cmd(cout),
		.cmd_take(take), .res_valid(rv), .res(rin), .res_full(rq_full)
	);

	cmfr_fifo #(.W($bits(res_t))) u_rq (
		.clk, .arst_n, .wr(rv), .wdata(rin), .full(rq_full),
		.rd(pop), .rdata(rout), .empty
	);

	assign out_mailbox = rout.out_mailbox;
	assign assigned = rout.assigned;
	assign assigned_id = rout.assigned_id;
	assign assigned_dlc = rout.assigned_dlc;
	assign assigned_entry = rout.assigned_entry;
	assign rx_entry = rout.rx_entry;
	assign entry0_count = rout.entry0_count;
	assign total_count = rout.total_count;
endmodule
